// ----- hdl/almrd_pkg.sv -----
`timescale 1ns / 1ps
package almrd_pkg;
    localparam int SAMPLE_W = 24;
    localparam int DB_W     = 16;
    localparam logic signed [DB_W-1:0] DB_FLOOR = -16'sd25600;
    localparam logic [31:0] AMP_MIN = 32'd21475;
    localparam logic [18:0] DB_PER_LOG2 = 19'd394566;
    localparam logic [0:0] REG_ENABLE = 1'b0;
    localparam logic [0:0] REG_SMOOTH = 1'b1;

    typedef enum logic [3:0] {
        CMD_NONE, CMD_DIV, CMD_SQRT, CMD_SMOOTH, CMD_LOG_RMS, CMD_LOG_PEAK, CMD_FINISH,
        CMD_LOAD
    } t_cmd;

    typedef struct packed {
        logic done;
    } t_status;
endpackage

// ----- hdl/almrd_datapath.sv -----
`timescale 1ns / 1ps
module almrd_datapath
    import almrd_pkg::*;
#(
    parameter int MAX_FRAMES = 4096,
    parameter int CNT_W = 13
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_acc_en,
    input  logic                 i_acc_clear,
    input  logic [SAMPLE_W-1:0]  i_sample,
    input  t_cmd                 i_cmd,
    input  logic [15:0]          i_factor,
    output t_status              o_status,
    output logic signed [DB_W-1:0] o_rms_db,
    output logic signed [DB_W-1:0] o_peak_db,
    output logic signed [DB_W-1:0] o_max_db
);
    localparam int SUM_W = 48 + CNT_W;

    typedef enum logic [2:0] {
        M_IDLE, M_DIV, M_ROOT, M_SMOOTH, M_LOG
    } t_mode;

    logic [SUM_W-1:0] r_sum;
    logic [CNT_W-1:0] r_cnt;
    logic [23:0]      r_peak;
    logic [23:0]      w_mag;
    logic [47:0]      r_sq;
    logic             r_sq_v;

    logic [SUM_W-1:0] r_rem, r_quo;
    logic [6:0]       r_step;
    logic [63:0]      r_rv;
    logic [33:0]      r_root, r_racc;
    logic [48:0]      r_blend;
    logic [31:0]      r_smooth;
    logic [31:0]      r_y;
    logic [15:0]      r_frac;
    logic [4:0]       r_pos;
    logic [31:0]      r_x;
    logic             r_small;
    logic [39:0]      r_prod;
    logic signed [DB_W-1:0] r_rms_db, r_peak_db, r_max_db, w_db;
    logic signed [DB_W-1:0] r_out_rms, r_out_peak, r_out_max;
    logic             r_busy, r_done, r_lpeak;
    t_mode            r_mode;
    logic [SUM_W-1:0] w_sum_end;
    logic [SUM_W:0]   w_trial;
    logic [35:0]      w_rt;
    logic [63:0]      w_sq;
    logic [47:0]      w_m1, w_m2;
    logic [4:0]       w_lz;
    logic [20:0]      w_m;
    logic [39:0]      w_mag_db;

    assign w_mag = i_sample[23] ? 24'(25'h1000000 - {1'b0, i_sample}) : i_sample;

    // Square is registered; the add lands in the following cycle.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_acc_clear) begin
            r_sum  <= '0;
            r_cnt  <= '0;
            r_peak <= '0;
            r_sq_v <= 1'b0;
        end else begin
            r_sq_v <= 1'b0;
            if (r_sq_v) r_sum <= r_sum + SUM_W'(r_sq);
            if (i_acc_en && (32'(r_cnt) < 32'(MAX_FRAMES))) begin
                r_sq   <= w_mag * w_mag;
                r_sq_v <= 1'b1;
                r_cnt  <= r_cnt + 1'b1;
                if (w_mag > r_peak) r_peak <= w_mag;
            end
        end
    end

    // The square of the last sample may still be on its way into the sum.
    assign w_sum_end = r_sq_v ? (r_sum + SUM_W'(r_sq)) : r_sum;

    assign w_trial = {1'b0, r_rem[SUM_W-2:0], r_quo[SUM_W-1]}
                   - {1'b0, {(SUM_W-CNT_W){1'b0}}, r_cnt};
    assign w_rt = {r_racc, r_rv[63:62]} - {r_root, 2'b01};
    assign w_sq = {32'd0, r_y} * {32'd0, r_y};

    always_comb begin
        w_lz = '0;
        for (int k = 0; k < 32; k++) if (r_x[k]) w_lz = 5'(k);
    end
    assign w_m = 21'(31 << 16) - {r_pos, r_frac};
    assign w_mag_db = (r_prod + 40'd8388608) >> 24;
    always_comb begin
        if (r_small) w_db = DB_FLOOR;
        else if (w_mag_db > 40'd25600) w_db = DB_FLOOR;
        else w_db = -$signed(DB_W'(w_mag_db));
    end

    assign w_m1 = 48'(r_smooth) * 48'(17'h10000 - 17'(i_factor));
    assign w_m2 = 48'(r_root[31:0]) * 48'(i_factor);

    // Back part: one shared multi-cycle engine stepping per command.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_smooth <= '0;
            r_max_db <= DB_FLOOR;
            r_busy   <= 1'b0;
            r_done   <= 1'b0;
            r_mode   <= M_IDLE;
        end else begin
            r_done <= 1'b0;
            unique case (i_cmd)
                CMD_DIV: begin
                    r_rem <= '0; r_quo <= w_sum_end; r_step <= 7'(SUM_W);
                    r_mode <= M_DIV; r_busy <= 1'b1;
                end
                CMD_SQRT: begin
                    r_rv <= (r_cnt == '0) ? '0 : {r_quo[47:0], 16'h0};
                    r_root <= '0; r_racc <= '0; r_step <= 7'd32;
                    r_mode <= M_ROOT; r_busy <= 1'b1;
                end
                CMD_SMOOTH: begin
                    r_step <= 7'd2; r_mode <= M_SMOOTH; r_busy <= 1'b1;
                end
                CMD_LOG_RMS, CMD_LOG_PEAK: begin
                    r_x <= (i_cmd == CMD_LOG_RMS) ? r_smooth : {r_peak, 8'h0};
                    r_lpeak <= (i_cmd == CMD_LOG_PEAK);
                    r_step <= 7'd20; r_mode <= M_LOG; r_busy <= 1'b1;
                end
                CMD_FINISH: begin
                    if (r_peak_db > r_max_db) r_max_db <= r_peak_db;
                end
                CMD_LOAD: begin
                    r_out_rms  <= r_rms_db;
                    r_out_peak <= r_peak_db;
                    r_out_max  <= r_max_db;
                end
                default: begin
                    if (r_busy) begin
                        r_step <= r_step - 1'b1;
                        if (r_step == 7'd1) begin r_busy <= 1'b0; r_done <= 1'b1; end
                        case (r_mode)
                            M_DIV: begin
                                if (!w_trial[SUM_W]) begin
                                    r_rem <= w_trial[SUM_W-1:0];
                                    r_quo <= {r_quo[SUM_W-2:0], 1'b1};
                                end else begin
                                    r_rem <= {r_rem[SUM_W-2:0], r_quo[SUM_W-1]};
                                    r_quo <= {r_quo[SUM_W-2:0], 1'b0};
                                end
                            end
                            M_ROOT: begin
                                r_rv <= {r_rv[61:0], 2'b00};
                                if (!w_rt[35]) begin
                                    r_racc <= w_rt[33:0]; r_root <= {r_root[32:0], 1'b1};
                                end else begin
                                    r_racc <= {r_racc[31:0], r_rv[63:62]};
                                    r_root <= {r_root[32:0], 1'b0};
                                end
                            end
                            M_SMOOTH: begin
                                if (r_step == 7'd2) r_blend <= 49'(w_m1) + 49'(w_m2);
                                else r_smooth <= 32'((r_blend + 49'd32768) >> 16);
                            end
                            M_LOG: begin
                                if (r_step == 7'd20) begin
                                    r_small <= r_x < AMP_MIN; r_pos <= w_lz;
                                    r_y <= r_x << (5'd31 - w_lz); r_frac <= '0;
                                end else if (r_step > 7'd3) begin
                                    if (w_sq[63]) begin
                                        r_y <= w_sq[63:32]; r_frac <= {r_frac[14:0], 1'b1};
                                    end else begin
                                        r_y <= w_sq[62:31]; r_frac <= {r_frac[14:0], 1'b0};
                                    end
                                end else if (r_step == 7'd3) begin
                                    if ({r_pos, r_frac} >= 21'(31 << 16)) r_prod <= '0;
                                    else r_prod <= 40'(w_m) * 40'(DB_PER_LOG2);
                                end else if (r_step == 7'd2) begin
                                    if (r_lpeak) r_peak_db <= w_db; else r_rms_db <= w_db;
                                end
                            end
                            default: ;
                        endcase
                    end
                end
            endcase
        end
    end

    assign o_status.done = r_done;
    assign o_rms_db  = r_out_rms;
    assign o_peak_db = r_out_peak;
    assign o_max_db  = r_out_max;
endmodule

// ----- hdl/almrd_ctrl.sv -----
`timescale 1ns / 1ps
module almrd_ctrl
    import almrd_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_end,
    input  logic    i_out_take,
    input  t_status i_status,
    output logic    o_busy,
    output logic    o_out_valid,
    output logic    o_acc_clear,
    output t_cmd    o_cmd
);
    typedef enum logic [3:0] {
        S_IDLE, S_FLUSH, S_DIV, S_SQRT, S_SMOOTH, S_LRMS, S_LPEAK, S_FIN, S_OUT
    } t_state;
    t_state r_state;
    logic   r_out_valid;
    t_cmd   w_cmd;

    always_comb begin
        w_cmd = CMD_NONE;
        if (r_state == S_FLUSH) w_cmd = CMD_DIV;
        else if (r_state == S_OUT) w_cmd = CMD_LOAD;
        else if (i_status.done) begin
            unique case (r_state)
                S_DIV:    w_cmd = CMD_SQRT;
                S_SQRT:   w_cmd = CMD_SMOOTH;
                S_SMOOTH: w_cmd = CMD_LOG_RMS;
                S_LRMS:   w_cmd = CMD_LOG_PEAK;
                S_LPEAK:  w_cmd = CMD_FINISH;
                default:  w_cmd = CMD_NONE;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            if (i_out_take) r_out_valid <= 1'b0;
            unique case (r_state)
                S_IDLE:   if (i_end) r_state <= S_FLUSH;
                S_FLUSH:  r_state <= S_DIV;
                S_DIV:    if (i_status.done) r_state <= S_SQRT;
                S_SQRT:   if (i_status.done) r_state <= S_SMOOTH;
                S_SMOOTH: if (i_status.done) r_state <= S_LRMS;
                S_LRMS:   if (i_status.done) r_state <= S_LPEAK;
                S_LPEAK:  if (i_status.done) r_state <= S_FIN;
                S_FIN:    if (!r_out_valid || i_out_take) r_state <= S_OUT;
                S_OUT: begin
                    r_out_valid <= 1'b1;
                    r_state <= S_IDLE;
                end
                default:  r_state <= S_IDLE;
            endcase
        end
    end

    assign o_cmd       = w_cmd;
    assign o_busy      = (r_state != S_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_acc_clear = (r_state == S_OUT);
endmodule

// ----- hdl/audio_level_meter_rms_peak_db_unit.sv -----
`timescale 1ns / 1ps
// Channel  Direction  Handshake        Payload
// in       input      valid / stall    sample, last_sample, muted
// out      output     valid / stall    rms_db, peak_db, max_peak_db
// cfg      input      valid / ready    index, data
// Samples are taken one per cycle while o_stall is low. A buffer end taken
// while enabled and not muted starts the back part, which stalls the input:
// a bit-serial divide, a bit-serial root, a smoothing step and two log steps
// (rms, then peak), each started by a command, then the result is handed off.
// Reset is synchronous, active low. A result waiting under stall holds its
// payload; the block takes samples meanwhile, and a later buffer end waits
// before its result until it is taken.
module audio_level_meter_rms_peak_db_unit
    import almrd_pkg::*;
#(
    parameter int MAX_FRAMES = 4096
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_valid,
    output logic                   o_stall,
    input  logic signed [23:0]     i_sample,
    input  logic                   i_last_sample,
    input  logic                   i_muted,
    output logic                   o_valid,
    input  logic                   i_stall,
    output logic signed [15:0]     o_rms_db,
    output logic signed [15:0]     o_peak_db,
    output logic signed [15:0]     o_max_peak_db,
    input  logic                   i_cfg_valid,
    output logic                   o_cfg_ready,
    input  logic [0:0]             i_cfg_index,
    input  logic [15:0]            i_cfg_data
);
    localparam int CNT_W = $clog2(MAX_FRAMES + 1);

    logic        r_enable;
    logic [15:0] r_factor;
    logic        w_take, w_busy, w_clear, w_end, w_ign;
    t_cmd        w_cmd;
    t_status     w_status;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_enable <= 1'b0;
            r_factor <= 16'd6554;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                REG_ENABLE: r_enable <= i_cfg_data[0];
                REG_SMOOTH: r_factor <= i_cfg_data;
                default: ;
            endcase
        end
    end
    assign o_cfg_ready = 1'b1;

    assign o_stall = w_busy;
    assign w_take  = i_valid && !w_busy;
    assign w_ign   = !r_enable || i_muted;
    assign w_end   = w_take && i_last_sample && !w_ign;

    almrd_datapath #(.MAX_FRAMES(MAX_FRAMES), .CNT_W(CNT_W)) u_dp (
        .i_clk, .i_rst_n,
        .i_acc_en(w_take && !w_ign),
        .i_acc_clear(w_clear || (w_take && i_last_sample && w_ign)),
        .i_sample(i_sample),
        .i_cmd(w_cmd),
        .i_factor(r_factor),
        .o_status(w_status),
        .o_rms_db(o_rms_db),
        .o_peak_db(o_peak_db),
        .o_max_db(o_max_peak_db)
    );

    almrd_ctrl u_ctrl (
        .i_clk, .i_rst_n,
        .i_end(w_end),
        .i_out_take(o_valid && !i_stall),
        .i_status(w_status),
        .o_busy(w_busy),
        .o_out_valid(o_valid),
        .o_acc_clear(w_clear),
        .o_cmd(w_cmd)
    );
endmodule

// ----- sim/tb_top.sv -----
`timescale 1ns / 1ps
module tb_top;
    import almrd_pkg::*;

    typedef struct {
        logic signed [15:0] rms_db;
        logic signed [15:0] peak_db;
        logic signed [15:0] max_peak_db;
    } t_level;

    class level_scoreboard;
        bit                 enable;
        bit [15:0]          smooth_f;
        longint unsigned    sq_sum;
        int unsigned        n_samples;
        int unsigned        peak_mag;
        longint unsigned    smooth_lvl;
        logic signed [15:0] max_db;
        t_level             expected_levels[$];
        int                 errors;

        function new();
            enable     = 0;
            smooth_f   = 16'd6554;
            sq_sum     = 0;
            n_samples  = 0;
            peak_mag   = 0;
            smooth_lvl = 0;
            max_db     = DB_FLOOR;
            errors     = 0;
        endfunction

        function void write_reg(logic [0:0] idx, logic [15:0] data);
            if (idx == REG_ENABLE) enable = data[0];
            else if (idx == REG_SMOOTH) smooth_f = data;
        endfunction

        function longint unsigned int_sqrt(longint unsigned v);
            longint unsigned r;
            longint unsigned b;
            r = 0;
            b = 64'd1 << 62;
            while (b > v) b >>= 2;
            while (b != 0) begin
                if (v >= r + b) begin
                    v -= r + b;
                    r = (r >> 1) + b;
                end else begin
                    r >>= 1;
                end
                b >>= 2;
            end
            return r;
        endfunction

        // Q1.31 amplitude to Q8.8 dB via a log2 built by repeated squaring.
        function logic signed [15:0] amp_to_db(longint unsigned x);
            int unsigned     p;
            longint unsigned y;
            longint unsigned frac;
            longint unsigned lg;
            longint unsigned mag;
            if (x < AMP_MIN) return DB_FLOOR;
            p = 0;
            while (p < 31 && (x >> (p + 1)) != 0) p++;
            y = x << (31 - p);
            frac = 0;
            for (int i = 0; i < 16; i++) begin
                y = (y * y) >> 31;
                frac <<= 1;
                if (y >= (64'd1 << 32)) begin
                    y >>= 1;
                    frac |= 1;
                end
            end
            lg = (longint'(p) << 16) + frac;
            if (lg >= (64'd31 << 16)) return 16'sd0;
            mag = (((64'd31 << 16) - lg) * DB_PER_LOG2 + (64'd1 << 23)) >> 24;
            if (mag > 25600) mag = 25600;
            return -$signed(16'(mag));
        endfunction

        function void note_sample(logic signed [23:0] smp, bit last, bit muted);
            int unsigned     m;
            longint unsigned rms;
            t_level          e;
            if (!enable || muted) begin
                if (last) begin
                    sq_sum = 0; n_samples = 0; peak_mag = 0;
                end
                return;
            end
            m = smp[23] ? (32'h1000000 - {8'd0, smp}) : {8'd0, smp};
            if (n_samples < 4096) begin
                sq_sum += longint'(m) * m;
                n_samples++;
                if (m > peak_mag) peak_mag = m;
            end
            if (!last) return;
            rms = 0;
            if (n_samples != 0) rms = int_sqrt((sq_sum / n_samples) << 16);
            smooth_lvl = (smooth_lvl * (65536 - smooth_f) + rms * smooth_f + 32768) >> 16;
            smooth_lvl &= 64'hFFFF_FFFF;
            e.rms_db  = amp_to_db(smooth_lvl);
            e.peak_db = amp_to_db(longint'(peak_mag) << 8);
            if (e.peak_db > max_db) max_db = e.peak_db;
            e.max_peak_db = max_db;
            expected_levels.push_back(e);
            sq_sum = 0; n_samples = 0; peak_mag = 0;
        endfunction

        function void check_levels(logic signed [15:0] rms, logic signed [15:0] pk,
                                   logic signed [15:0] mx);
            t_level e;
            if (expected_levels.size() == 0) begin
                $error("unexpected result rms_db=%0d peak_db=%0d", rms, pk);
                errors++;
                return;
            end
            e = expected_levels.pop_front();
            if (rms !== e.rms_db) begin
                $error("rms_db expected %0d actual %0d", e.rms_db, rms);
                errors++;
            end
            if (pk !== e.peak_db) begin
                $error("peak_db expected %0d actual %0d", e.peak_db, pk);
                errors++;
            end
            if (mx !== e.max_peak_db) begin
                $error("max_peak_db expected %0d actual %0d", e.max_peak_db, mx);
                errors++;
            end
        endfunction
    endclass

    logic               i_clk = 0;
    logic               i_rst_n = 0;
    logic               i_valid = 0;
    logic               o_stall;
    logic signed [23:0] i_sample = 0;
    logic               i_last_sample = 0;
    logic               i_muted = 0;
    logic               o_valid;
    logic               i_stall = 0;
    logic signed [15:0] o_rms_db, o_peak_db, o_max_peak_db;
    logic               i_cfg_valid = 0;
    logic               o_cfg_ready;
    logic [0:0]         i_cfg_index = 0;
    logic [15:0]        i_cfg_data = 0;

    level_scoreboard sb = new();
    int send_idle_pct = 0;
    int stall_pct = 0;

    audio_level_meter_rms_peak_db_unit u_dut (.*);

    always #4 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && !i_stall)
            sb.check_levels(o_rms_db, o_peak_db, o_max_peak_db);
        i_stall <= ($urandom_range(99) < stall_pct);
    end

    task automatic write_cfg(logic [0:0] idx, logic [15:0] data);
        i_valid <= 0;
        while (sb.expected_levels.size() != 0) @(posedge i_clk);
        repeat (300) @(posedge i_clk);
        i_cfg_valid <= 1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        do @(posedge i_clk); while (!o_cfg_ready);
        sb.write_reg(idx, data);
        i_cfg_valid <= 0;
    endtask

    task automatic send_sample(logic signed [23:0] smp, bit last, bit muted);
        i_valid       <= 1;
        i_sample      <= smp;
        i_last_sample <= last;
        i_muted       <= muted;
        do @(posedge i_clk); while (o_stall);
        sb.note_sample(smp, last, muted);
        if ($urandom_range(99) < send_idle_pct) begin
            i_valid <= 0;
            repeat ($urandom_range(1, 4)) @(posedge i_clk);
        end
    endtask

    function automatic logic signed [23:0] rand_sample();
        logic signed [23:0] s;
        s = 24'($urandom);
        // Scale down often so both quiet and loud levels show up.
        return s >>> $urandom_range(23);
    endfunction

    task automatic send_buffer(int len, bit muted);
        for (int i = 0; i < len; i++)
            send_sample(rand_sample(), i == len - 1, muted);
    endtask

    task automatic random_phase(int n_items);
        int sent;
        int len;
        sent = 0;
        while (sent < n_items) begin
            len = $urandom_range(1, 16);
            send_buffer(len, $urandom_range(9) == 0);
            sent += len;
        end
        i_valid <= 0;
    endtask

    initial begin
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1;
        @(posedge i_clk);

        // Disabled after reset: ignored.
        send_sample(24'sd8388607, 1, 0);
        write_cfg(REG_ENABLE, 16'd1);
        write_cfg(REG_SMOOTH, 16'd65535);
        send_sample(24'sd8388607, 1, 0);
        send_sample(-24'sd8388608, 1, 0);
        send_sample(24'sd0, 1, 0);
        send_sample(24'sd1, 1, 0);
        send_sample(-24'sd1, 1, 0);
        send_sample(24'sd100, 1, 0);
        send_sample(24'sd200000, 0, 0);
        send_sample(-24'sd3000, 1, 0);
        send_sample(24'sd8388607, 0, 1);
        send_sample(24'sd8388607, 1, 1);
        send_sample(24'sd5000, 0, 0);
        send_sample(24'sd6000, 1, 0);
        i_valid <= 0;

        write_cfg(REG_SMOOTH, 16'd6554);
        random_phase(140);
        write_cfg(REG_SMOOTH, 16'd0);
        send_idle_pct = 47;
        random_phase(140);
        write_cfg(REG_SMOOTH, 16'(($urandom)));
        send_idle_pct = 0;
        stall_pct = 47;
        random_phase(140);
        write_cfg(REG_ENABLE, 16'd0);
        random_phase(30);
        write_cfg(REG_ENABLE, 16'd1);
        write_cfg(REG_SMOOTH, 16'd65535);
        send_idle_pct = 20;
        stall_pct = 20;
        random_phase(140);
        write_cfg(REG_SMOOTH, 16'd32768);
        send_idle_pct = 0;
        stall_pct = 0;
        random_phase(120);

        while (sb.expected_levels.size() != 0) @(posedge i_clk);
        repeat (300) @(posedge i_clk);
        if (sb.errors == 0)
            $display("audio_level_meter_rms_peak_db_unit: match");
        else
            $display("audio_level_meter_rms_peak_db_unit: mismatch");
        $finish;
    end

    initial begin
        #20ms;
        $display("audio_level_meter_rms_peak_db_unit: mismatch");
        $finish;
    end
endmodule

// ----- audio_level_meter_rms_peak_db_unit.f -----
hdl/almrd_pkg.sv
hdl/almrd_datapath.sv
hdl/almrd_ctrl.sv
hdl/audio_level_meter_rms_peak_db_unit.sv
sim/tb_top.sv
